/* src/sorted_table_binary_search_core_macros.svh */
// assertion macros for the sorted table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define STBS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STBS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/stbs_pkg.sv */
// shared constants and types of the sorted table search block
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 32;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_EXACT = 2'd1;
    localparam logic [1:0] MODE_FIRST = 2'd2;
    localparam logic [1:0] MODE_LAST  = 2'd3;

    // classified command handed from front to back
    typedef struct packed {
        logic       is_load;
        logic [1:0] mode;
    } stbs_cmd_t;

endpackage

/* src/sorted_table_binary_search_core.sv */
// top level of the sorted table binary search block
// usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes table_length; values above
//   the table depth saturate to the depth. write it only while the block is idle
//   input channel (in_valid/in_ready) carries one beat per item: mode 0 loads
//   item_value at entry_index, modes 1..3 search for item_value (exact, first
//   occurrence, last occurrence) over entries 0..table_length-1
//   output channel (out_valid/out_ready) returns found and position, one beat per
//   search and none per load; a miss gives found 0, position 0
// sequence:
//   a load is a single ram write from the idle state of the back end; a search
//   issues the first table read from idle, then makes one probe per cycle through
//   the single ram read port (at most floor(log2(table_length)) + 1 probes, 11 at
//   depth 1024), then the done state loads the result register once it is free
// a two-beat command queue sits between input and back end, so inputs keep being
// taken while a search runs; when the receiver stalls, the result register holds
// and the back end waits, then the queue fills and in_ready drops
// reset clears table_length, the queue and the sequencer; table contents are
// undefined until loaded
`timescale 1ns / 1ps

module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = stbs_pkg::DEF_VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   entry_index,
    input  logic [VALUE_BITS-1:0]            item_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [$clog2(TABLE_DEPTH)-1:0]   position
);

    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

    logic [LEN_W-1:0]      table_length_reg, table_length_next;
    logic                  q_valid;
    logic                  q_pop;
    stbs_cmd_t             q_cmd;
    logic [IDX_W-1:0]      q_index;
    logic [VALUE_BITS-1:0] q_value;

    // config is always taken; saturate the length at the table depth
    assign cfg_ready = 1'b1;

    always_comb
    begin
        table_length_next = table_length_reg;
        if (cfg_valid)
        begin
            if (cfg_data > LEN_W'(TABLE_DEPTH))
            begin
                table_length_next = LEN_W'(TABLE_DEPTH);
            end
            else
            begin
                table_length_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else
        begin
            table_length_reg <= table_length_next;
        end
    end

    // front: accept and classify, queue commands
    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .entry_index (entry_index),
        .item_value  (item_value),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .q_index     (q_index),
        .q_value     (q_value)
    );

    // back: ram writes for loads, one probe per cycle for searches
    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_length (table_length_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .q_index      (q_index),
        .q_value      (q_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .position     (position)
    );

endmodule

/* src/stbs_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/stbs_front.sv */
// front end: takes input beats, classifies them and queues commands
`timescale 1ns / 1ps

module stbs_front #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = stbs_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0] entry_index,
    input  logic [VALUE_BITS-1:0]          item_value,
    output logic                           q_valid,
    input  logic                           q_pop,
    output stbs_pkg::stbs_cmd_t            q_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] q_index,
    output logic [VALUE_BITS-1:0]          q_value
);

    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    stbs_cmd_t             cmd_reg   [2];
    logic [IDX_W-1:0]      index_reg [2];
    logic [VALUE_BITS-1:0] value_reg [2];
    logic [1:0]            count_reg, count_next;
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    stbs_cmd_t             cmd_in;
    logic                  keep;
    logic                  push;
    logic                  pop;

    // loads beyond the table are dropped here
    always_comb
    begin
        cmd_in.is_load = (mode == MODE_LOAD);
        cmd_in.mode    = mode;
        keep = !cmd_in.is_load || ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_DEPTH));
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg]   <= cmd_in;
            index_reg[wr_ptr_reg] <= entry_index;
            value_reg[wr_ptr_reg] <= item_value;
        end
    end

    assign q_cmd   = cmd_reg[rd_ptr_reg];
    assign q_index = index_reg[rd_ptr_reg];
    assign q_value = value_reg[rd_ptr_reg];

endmodule

/* src/stbs_back.sv */
// back end: table ram, probe sequencer and result register
`timescale 1ns / 1ps

module stbs_back #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = stbs_pkg::DEF_VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] table_length,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  stbs_pkg::stbs_cmd_t              q_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   q_index,
    input  logic [VALUE_BITS-1:0]            q_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [$clog2(TABLE_DEPTH)-1:0]   position
);

    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] key_reg;
    logic [1:0]            mode_reg;
    logic [LEN_W-1:0]      s_reg, s_next;
    logic [LEN_W-1:0]      e1_reg, e1_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_pos_reg, hit_pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg;
    logic [IDX_W-1:0]      position_reg;

    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;

    logic                  start;
    logic                  out_free;
    logic                  is_eq;
    logic                  key_gt;
    logic [LEN_W-1:0]      mid_ext;
    logic [LEN_W-1:0]      span;

    stbs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (q_index),
        .wr_data (q_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign q_pop     = (state_reg == ST_IDLE);
    assign start     = q_pop && q_valid && !q_cmd.is_load;
    assign ram_wr_en = q_pop && q_valid && q_cmd.is_load;
    assign out_free  = !out_valid_reg || out_ready;

    assign is_eq   = ($signed(ram_rd_data) == $signed(key_reg));
    assign key_gt  = ($signed(key_reg) > $signed(ram_rd_data));
    assign mid_ext = LEN_W'(mid_reg);

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        e1_next        = e1_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        hit_pos_next   = hit_pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = mid_reg;
        span           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    hit_next     = 1'b0;
                    hit_pos_next = '0;
                    s_next       = '0;
                    e1_next      = table_length;
                    if (table_length == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mid_next    = IDX_W'((table_length - LEN_W'(1)) >> 1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = mid_next;
                        state_next  = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                // read data belongs to mid_reg, issued last cycle
                if (is_eq)
                begin
                    hit_next     = 1'b1;
                    hit_pos_next = mid_reg;
                    if (mode_reg == MODE_FIRST)
                    begin
                        e1_next = mid_ext;
                    end
                    else
                    begin
                        s_next = mid_ext + LEN_W'(1);
                    end
                end
                else if (key_gt)
                begin
                    s_next = mid_ext + LEN_W'(1);
                end
                else
                begin
                    e1_next = mid_ext;
                end
                if ((is_eq && (mode_reg == MODE_EXACT)) || (s_next >= e1_next))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    span        = e1_next - s_next - LEN_W'(1);
                    mid_next    = IDX_W'(s_next + (span >> 1));
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_next;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        e1_reg      <= e1_next;
        mid_reg     <= mid_next;
        hit_reg     <= hit_next;
        hit_pos_reg <= hit_pos_next;
        if (start)
        begin
            key_reg  <= q_value;
            mode_reg <= q_cmd.mode;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            found_reg    <= hit_reg;
            position_reg <= hit_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

/* src/stbs_checker.sv */
// port-level checks for the sorted table search block, bound to the top level
`timescale 1ns / 1ps
`include "sorted_table_binary_search_core_macros.svh"

module stbs_checker #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [1:0]                     mode,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           found,
    input logic [$clog2(TABLE_DEPTH)-1:0] position
);

    import stbs_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       search_in;
    logic       result_out;

    // searches taken but not yet answered
    assign search_in  = in_valid && in_ready && (mode != MODE_LOAD);
    assign result_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (search_in && !result_out)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (result_out && !search_in)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `STBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(position), "stalled result changed")
    `STBS_ASSERT_NOW(a_miss_zero, out_valid && !found, position == '0, "miss with nonzero position")
    `STBS_ASSERT_NOW(a_no_extra, out_valid, pending_reg != 3'd0, "result without a pending search")

endmodule

bind sorted_table_binary_search_core stbs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_stbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position)
);

/* test/tb_sorted_table_binary_search_core.sv */
// testbench for the sorted table binary search block: loads, searches, length changes
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_core;

    import stbs_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int VB    = DEF_VALUE_BITS;
    localparam int IW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);

    localparam longint VALUE_MAX = (longint'(1) << (VB - 1)) - 1;
    localparam longint VALUE_MIN = -(longint'(1) << (VB - 1));

    // no new phase of stimulus starts once this many beats went in
    localparam int ITEM_TARGET   = 1950;
    // cycles left after the last answer so trailing loads leave the command queue
    localparam int SETTLE_CYCLES = 32;
    // long receiver hold-off, enough to fill the queue and drop in_ready
    localparam int HOLD_CYCLES   = 300;
    // cycles without any beat on any channel before the run is called hung
    localparam int QUIET_LIMIT   = 5000;

    // one search answer: found flag and chosen index
    typedef struct packed {
        logic          found;
        logic [IW-1:0] position;
    } lookup_t;

    // mirror of the table and length, plus the answers still owed by the block
    class search_scoreboard;
        logic signed [VB-1:0] entries [DEPTH];
        logic [LW-1:0]        length;
        lookup_t              answers_due [$];
        int                   failures;

        function new();
            length   = '0;
            failures = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        function void set_length(logic [LW-1:0] len);
            length = len;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // bisection over the live range, returns the chosen index or -1 on a miss
        function int bisect(logic [1:0] m, logic signed [VB-1:0] key);
            int lo;
            int hi;
            int mid;
            int hit;
            lo  = 0;
            hi  = ((length > DEPTH) ? DEPTH : int'(length)) - 1;
            hit = -1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] == key)
                begin
                    hit = mid;
                    if (m == MODE_EXACT)
                        return mid;
                    if (m == MODE_FIRST)
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
                else if (key > entries[mid])
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return hit;
        endfunction

        // called on every accepted input beat
        function void note_item(logic [1:0] m, logic [IW-1:0] idx, logic [VB-1:0] val);
            lookup_t a;
            int      hit;
            if (m == MODE_LOAD)
            begin
                entries[idx] = val;
                return;
            end
            hit        = bisect(m, val);
            a.found    = (hit >= 0);
            a.position = (hit >= 0) ? hit[IW-1:0] : '0;
            answers_due.push_back(a);
        endfunction

        // called on every accepted output beat
        function void check_answer(logic f, logic [IW-1:0] pos);
            lookup_t a;
            if (answers_due.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected answer: found=%0d position=%0d", f, pos);
                failures++;
                return;
            end
            a = answers_due.pop_front();
            if (f !== a.found || pos !== a.position)
            begin
                if (failures < 10)
                    $display("answer mismatch: expected found=%0d position=%0d, %s%0d %s%0d",
                             a.found, a.position, "got found=", f, "position=", pos);
                failures++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [LW-1:0] cfg_data;
    logic          in_valid;
    logic          in_ready;
    logic [1:0]    mode;
    logic [IW-1:0] entry_index;
    logic [VB-1:0] item_value;
    logic          out_valid;
    logic          out_ready;
    logic          found;
    logic [IW-1:0] position;

    search_scoreboard sb;

    // per phase idling odds, in percent of cycles
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    // request for one long receiver hold-off
    bit          hold_out;
    int          items_sent;
    // entries written since reset; a search never probes one that is not
    bit          loaded [DEPTH];
    bit          table_full;

    sorted_table_binary_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .entry_index (entry_index),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls per phase, or one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // result beats are checked against the oldest owed answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_answer(found, position);
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // one input beat; entered and left just after a falling edge
    task automatic send_item(input logic [1:0] m, input logic [IW-1:0] idx,
                             input logic [VB-1:0] val);
        // sender gap between beats; besides drain, this is the only place valid drops
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        item_value  <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(m, idx, val);
        items_sent++;
        @(negedge clk);
    endtask

    // park the input and wait until every answer is back and the queue is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // table_length write, only while the block is idle
    task automatic write_length(input int unsigned len);
        cfg_valid <= 1'b1;
        cfg_data  <= len[LW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_length(len[LW-1:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ascending run with duplicates into entries 0..n-1, saturating at the top value
    task automatic load_sorted(input int n);
        longint v;
        longint stepmax;
        case ($urandom_range(0, 3))
            0:       stepmax = 1;
            1:       stepmax = 16;
            2:       stepmax = 1 << 20;
            default: stepmax = 1 << 26;
        endcase
        case ($urandom_range(0, 7))
            0:       v = VALUE_MIN;
            1:       v = longint'($urandom_range(0, 200)) - 100;
            default: v = longint'(int'($urandom));
        endcase
        for (int i = 0; i < n; i++)
        begin
            send_item(MODE_LOAD, i[IW-1:0], v[VB-1:0]);
            loaded[i] = 1'b1;
            // about a quarter of the steps repeat the value
            if ($urandom_range(0, 3) != 0)
                v += $urandom_range(1, int'(stepmax));
            if (v > VALUE_MAX)
                v = VALUE_MAX;
        end
    endtask

    // one random search: mostly keys taken from the live table, some near misses
    task automatic search_random(input int span);
        logic [VB-1:0] key;
        logic [1:0]    m;
        int            pick;
        pick = $urandom_range(0, 9);
        if (span == 0 || pick >= 8)
            key = $urandom;
        else
        begin
            key = sb.entries[$urandom_range(0, span - 1)];
            if (pick >= 6)
                key = ($urandom_range(0, 1) != 0) ? key + 1'b1 : key - 1'b1;
        end
        case ($urandom_range(0, 2))
            0:       m = MODE_EXACT;
            1:       m = MODE_FIRST;
            default: m = MODE_LAST;
        endcase
        // entry_index is ignored by searches but still toggled
        send_item(m, IW'($urandom_range(0, DEPTH - 1)), key);
    endtask

    initial
    begin : stimulus
        int          p;
        int unsigned len;
        int          span;
        int          n;
        logic [IW-1:0] idx;

        sb           = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = MODE_LOAD;
        entry_index  = '0;
        item_value   = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_out     = 1'b0;
        items_sent   = 0;
        table_full   = 1'b0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: every mode misses
        write_length(0);
        send_item(MODE_EXACT, '0, '0);
        send_item(MODE_FIRST, '1, '1);
        send_item(MODE_LAST, '0, VALUE_MAX[VB-1:0]);

        // value extremes, a run of three duplicates and the top entry index
        send_item(MODE_LOAD, IW'(0), VALUE_MIN[VB-1:0]);
        send_item(MODE_LOAD, IW'(1), -VB'(5));
        send_item(MODE_LOAD, IW'(2), -VB'(5));
        send_item(MODE_LOAD, IW'(3), -VB'(5));
        send_item(MODE_LOAD, IW'(4), VALUE_MAX[VB-1:0]);
        send_item(MODE_LOAD, IW'(DEPTH - 1), VB'(42));
        for (int i = 0; i < 5; i++)
            loaded[i] = 1'b1;
        loaded[DEPTH - 1] = 1'b1;
        drain();
        write_length(5);

        // exact stops on the middle duplicate, first and last walk to the ends
        send_item(MODE_EXACT, '0, VALUE_MIN[VB-1:0]);
        send_item(MODE_FIRST, '0, -VB'(5));
        send_item(MODE_LAST, '0, -VB'(5));
        send_item(MODE_EXACT, '0, -VB'(5));
        send_item(MODE_LAST, '0, VALUE_MAX[VB-1:0]);
        send_item(MODE_FIRST, '0, '0);
        send_item(MODE_EXACT, '1, VALUE_MIN[VB-1:0] + 1'b1);
        drain();

        // random phases, each one length setting with its loads and searches
        p = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase

            // full depth once, then now and then full or saturating lengths
            if (p == 2)
                len = DEPTH;
            else if (table_full && $urandom_range(0, 5) == 0)
                case ($urandom_range(0, 2))
                    0:       len = DEPTH;
                    1:       len = (1 << LW) - 1;
                    default: len = $urandom_range(DEPTH + 1, (1 << LW) - 2);
                endcase
            else if ($urandom_range(0, 9) == 0)
                len = 0;
            else
                len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 24);
            write_length(len);
            span = (len > DEPTH) ? DEPTH : int'(len);

            if (p == 2)
            begin
                load_sorted(DEPTH);
                table_full = 1'b1;
            end
            else if (span > 64)
                // whole table stays written, only a prefix gets fresh sorted data
                load_sorted($urandom_range(1, 32));
            else if ($urandom_range(0, 7) != 0)
                load_sorted(span);
            else
                // keep old contents, just fill holes: usually leaves it unsorted
                for (int i = 0; i < span; i++)
                    if (!loaded[i])
                    begin
                        send_item(MODE_LOAD, i[IW-1:0], $urandom);
                        loaded[i] = 1'b1;
                    end

            // one phase with a long receiver hold-off while searches keep coming
            n = (p == 4) ? 40 : $urandom_range(6, 20);
            if (p == 4)
                hold_out = 1'b1;
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray load anywhere, may break the ordering of the live range
                    idx = IW'($urandom_range(0, DEPTH - 1));
                    send_item(MODE_LOAD, idx, $urandom);
                    loaded[idx] = 1'b1;
                end
                else
                    search_random(span);
            end
            drain();
            p++;
        end

        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
